// ===== src/fkrc_pkg.sv =====
// ----------------------------------------------------------------------------
// fkrc_pkg: shared definitions for the keyed row cache
// Sizes, derived widths and the structs passed along the cell chain.
// ----------------------------------------------------------------------------
package fkrc_pkg;

    localparam int CAPACITY  = 1024;
    localparam int ROW_WORDS = 16;
    localparam int KEY_W     = 64;
    localparam int WORD_W    = 32;
    localparam int SLOT_W    = $clog2(CAPACITY);
    localparam int WIDX_W    = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
    localparam int ADDR_W    = $clog2(CAPACITY * ROW_WORDS);

    // search token handed from cell to cell
    typedef struct packed {
        logic              tok;
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } t_probe;

    // operation broadcast to every cell during a sweep
    typedef struct packed {
        logic              commit;
        logic [KEY_W-1:0]  key;
        logic [SLOT_W-1:0] slot;
    } t_bcast;

endpackage

// ===== src/fkrc_cell.sv =====
// ----------------------------------------------------------------------------
// fkrc_cell: one cache slot
// Holds a key and its valid bit, matches the passing token and hands it on.
// ----------------------------------------------------------------------------
module fkrc_cell
    import fkrc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SLOT_W-1:0] i_idx,
    input  t_bcast            i_bc,
    input  t_probe            i_probe,
    output t_probe            o_probe
);

    logic [KEY_W-1:0]  r_key;
    logic              r_valid;
    logic              r_tok;
    logic              r_hit;
    logic [SLOT_W-1:0] r_slot;
    logic              match;
    logic              mine;

    assign match = r_valid && (r_key == i_bc.key);
    assign mine  = (i_idx == i_bc.slot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= 1'b0;
        end else begin
            r_tok <= i_probe.tok;
            if (i_probe.tok && i_bc.commit) begin
                if (mine) begin
                    r_valid <= 1'b1;
                end else if (match) begin
                    // drop older copy of a re-stored key
                    r_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_probe.tok && i_bc.commit && mine) begin
            r_key <= i_bc.key;
        end
        if (i_probe.tok) begin
            r_hit  <= i_probe.hit | (!i_bc.commit && match);
            r_slot <= match ? i_idx : i_probe.slot;
        end
    end

    assign o_probe.tok  = r_tok;
    assign o_probe.hit  = r_hit;
    assign o_probe.slot = r_slot;

endmodule

// ===== src/fkrc_chain.sv =====
// ----------------------------------------------------------------------------
// fkrc_chain: row of slot cells
// Passes a search or commit token from the first cell to the last.
// ----------------------------------------------------------------------------
module fkrc_chain
    import fkrc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_launch,
    input  t_bcast i_bc,
    output t_probe o_tail
);

    t_probe link [CAPACITY+1];

    assign link[0].tok  = i_launch;
    assign link[0].hit  = 1'b0;
    assign link[0].slot = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        fkrc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (SLOT_W'(g)),
            .i_bc    (i_bc),
            .i_probe (link[g]),
            .o_probe (link[g+1])
        );
    end

    assign o_tail = link[CAPACITY];

endmodule

// ===== src/fkrc_row_mem.sv =====
// ----------------------------------------------------------------------------
// fkrc_row_mem: row word storage
// One write port and one registered read port over all slot rows.
// ----------------------------------------------------------------------------
module fkrc_row_mem
    import fkrc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WORD_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] mem [CAPACITY*ROW_WORDS];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/fifo_keyed_row_cache.sv =====
// ----------------------------------------------------------------------------
// fifo_keyed_row_cache: fully associative row cache with ring replacement
// Keys sit in a chain of slot cells; row words sit in one memory.
// ----------------------------------------------------------------------------
// Use: the input channel (i_in_valid / o_in_ready) takes beats of func, key
// and word_in. A store beat (func=1) goes to a staging row. The beat that
// completes the row starts a commit: a token runs down the chain of CAPACITY
// cells, one cell a cycle, loading the key into the slot at the ring pointer
// and clearing any older slot holding the same key, while the staged words
// are copied into memory. The block stays busy until both are done.
// A lookup beat (func=0) sends a search token down the same chain, then
// returns ROW_WORDS result beats on o_out_valid / i_out_ready, each read
// from memory and then held in the output register, the last with o_last
// set; a miss gives zero words.
// One item is worked on at a time; o_in_ready is low while busy.
// A stalled receiver simply holds the current result beat; nothing is lost.
// Reset (synchronous, active low) clears all slot valid bits, the ring
// pointer and the staging position; no clearing pass is needed.
// ----------------------------------------------------------------------------
module fifo_keyed_row_cache
    import fkrc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_func,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [WORD_W-1:0] i_word_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_hit,
    output logic [WORD_W-1:0] o_word_out,
    output logic              o_last
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SWEEP = 2'd1;
    localparam logic [1:0] S_ISSUE = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    localparam logic [WIDX_W-1:0] WIDX_LAST = WIDX_W'(ROW_WORDS - 1);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(CAPACITY - 1);

    logic [1:0]        r_state;
    logic [WIDX_W-1:0] r_pos;
    logic [WIDX_W-1:0] r_cpy;
    logic              r_cpy_busy;
    logic [WIDX_W-1:0] r_k;
    logic [SLOT_W-1:0] r_ptr;
    logic [KEY_W-1:0]  r_key;
    logic              r_commit;
    logic              r_launch;
    logic              r_swept;
    logic              r_hit;
    logic [SLOT_W-1:0] r_hit_slot;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_stage [ROW_WORDS];

    t_bcast            bc;
    t_probe            tail;
    logic              in_acc;
    logic              done;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic [WORD_W-1:0] rdata;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign done       = r_swept && !r_cpy_busy;

    assign bc.commit = r_commit;
    assign bc.key    = r_key;
    assign bc.slot   = r_ptr;

    fkrc_chain u_chain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_launch (r_launch),
        .i_bc     (bc),
        .o_tail   (tail)
    );

    // copy staged words into the committed slot's row; read the hit slot's row
    assign mem_we = r_cpy_busy;
    assign waddr  = ADDR_W'(r_ptr) * ADDR_W'(ROW_WORDS) + ADDR_W'(r_cpy);
    assign mem_re = (r_state == S_ISSUE);
    assign raddr  = ADDR_W'(r_hit_slot) * ADDR_W'(ROW_WORDS) + ADDR_W'(r_k);

    fkrc_row_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (waddr),
        .i_wdata (r_stage[r_cpy]),
        .i_re    (mem_re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_cpy       <= '0;
            r_cpy_busy  <= 1'b0;
            r_k         <= '0;
            r_ptr       <= '0;
            r_launch    <= 1'b0;
            r_swept     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_launch <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_func) begin
                            if (r_pos == WIDX_LAST) begin
                                r_pos      <= '0;
                                r_launch   <= 1'b1;
                                r_swept    <= 1'b0;
                                r_cpy      <= '0;
                                r_cpy_busy <= 1'b1;
                                r_state    <= S_SWEEP;
                            end else begin
                                r_pos <= r_pos + 1'b1;
                            end
                        end else begin
                            r_launch <= 1'b1;
                            r_swept  <= 1'b0;
                            r_state  <= S_SWEEP;
                        end
                    end
                end
                S_SWEEP: begin
                    if (tail.tok) begin
                        r_swept <= 1'b1;
                    end
                    if (r_cpy_busy) begin
                        if (r_cpy == WIDX_LAST) begin
                            r_cpy_busy <= 1'b0;
                        end else begin
                            r_cpy <= r_cpy + 1'b1;
                        end
                    end
                    if (done) begin
                        if (r_commit) begin
                            // advance the ring past the slot just filled
                            r_ptr   <= (r_ptr == SLOT_LAST) ? '0 : r_ptr + 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= '0;
                            r_state <= S_ISSUE;
                        end
                    end
                end
                S_ISSUE: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        if (r_k == WIDX_LAST) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_ISSUE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers: staging row, operation and search result
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_key    <= i_key;
            r_commit <= i_func;
            if (i_func) begin
                r_stage[r_pos] <= i_word_in;
            end
        end
        if ((r_state == S_SWEEP) && tail.tok) begin
            r_hit      <= tail.hit;
            r_hit_slot <= tail.slot;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_hit;
    assign o_word_out  = r_hit ? rdata : '0;
    assign o_last      = (r_k == WIDX_LAST);

    a_out_in_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_state == S_OUT))
        else $error("result beat shown outside output state");

    a_ready_no_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !r_cpy_busy)
        else $error("input taken while row copy still running");

    a_tail_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tail.tok |-> (r_state == S_SWEEP))
        else $error("chain token left the chain outside a sweep");

    a_row_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_func && (r_pos == WIDX_LAST)) |=> (r_launch && r_cpy_busy))
        else $error("completed row did not start a commit");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last) |=> o_in_ready)
        else $error("block not idle after final result beat");

endmodule

// ===== test/fifo_keyed_row_cache_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_keyed_row_cache_tb: self-checking bench for the keyed row cache
// Drives store and lookup beats, keeps its own model of slots, keys and rows,
// and checks every returned word beat against it, under varied flow control.
// ----------------------------------------------------------------------------
module fifo_keyed_row_cache_tb;
    import fkrc_pkg::*;

    localparam int N_RANDOM  = 210;
    localparam int CYC_LIMIT = 2000000;
    localparam int HOLD_CYC  = 3000;

    typedef enum logic {OP_LOOKUP = 1'b0, OP_STORE = 1'b1} t_op;

    typedef struct packed {
        logic              hit;
        logic [WORD_W-1:0] word;
        logic              last;
    } t_beat;

    typedef struct packed {
        t_op               op;
        logic [KEY_W-1:0]  key;
        logic [WORD_W-1:0] word;
        logic              miss_known;   // expected result typed in: a miss
    } t_stim_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic              i_func = 1'b0;
    logic [KEY_W-1:0]  i_key = '0;
    logic [WORD_W-1:0] i_word_in = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic              o_hit;
    logic [WORD_W-1:0] o_word_out;
    logic              o_last;

    fifo_keyed_row_cache u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .i_key       (i_key),
        .i_word_in   (i_word_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_hit       (o_hit),
        .o_word_out  (o_word_out),
        .o_last      (o_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Own model of the cache contents
    // ------------------------------------------------------------------
    logic [KEY_W-1:0]  slot_key  [CAPACITY];
    logic              slot_vld  [CAPACITY];
    logic [WORD_W-1:0] slot_row  [CAPACITY][ROW_WORDS];
    logic [WORD_W-1:0] stage_row [ROW_WORDS];
    int unsigned       ring_ptr;
    int unsigned       stage_pos;

    t_beat             pending_beats[$];
    int                n_errors;
    int                sender_idle_pct;
    int                recv_stall_pct;
    logic              hold_off;
    logic              start_hold;

    // Absorb one store word; commit the row when it is complete.
    function automatic void cache_store(logic [KEY_W-1:0] key, logic [WORD_W-1:0] word);
        stage_row[stage_pos] = word;
        if (stage_pos + 1 >= ROW_WORDS) begin
            stage_pos = 0;
            // a key stored again lives only in its newest slot
            for (int i = 0; i < CAPACITY; i++) begin
                if (i != ring_ptr && slot_vld[i] && slot_key[i] == key)
                    slot_vld[i] = 1'b0;
            end
            for (int k = 0; k < ROW_WORDS; k++)
                slot_row[ring_ptr][k] = stage_row[k];
            slot_key[ring_ptr] = key;
            slot_vld[ring_ptr] = 1'b1;
            ring_ptr = (ring_ptr + 1) % CAPACITY;
        end else begin
            stage_pos = stage_pos + 1;
        end
    endfunction

    // Queue the row words a lookup should return (zeros on a miss).
    function automatic void cache_lookup(logic [KEY_W-1:0] key, logic force_miss);
        logic found;
        int   slot;
        t_beat b;
        found = 1'b0;
        slot  = 0;
        if (!force_miss) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (slot_vld[i] && slot_key[i] == key) begin
                    found = 1'b1;
                    slot  = i;
                end
            end
        end
        for (int k = 0; k < ROW_WORDS; k++) begin
            b.hit  = found;
            b.word = found ? slot_row[slot][k] : '0;
            b.last = (k == ROW_WORDS - 1);
            pending_beats.insert(pending_beats.size(), b);
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side: offer one beat, idle at random beforehand
    // ------------------------------------------------------------------
    task automatic offer_beat(t_op op, logic [KEY_W-1:0] key,
                              logic [WORD_W-1:0] word, logic miss_known);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= op;
        i_key      <= key;
        i_word_in  <= word;
        // hold the beat until the block takes it
        do @(posedge i_clk); while (!o_in_ready);
        if (op == OP_STORE)
            cache_store(key, word);
        else
            cache_lookup(key, miss_known);
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        hold_off = 1'b0;
        wait (start_hold);
        hold_off = 1'b1;
        repeat (HOLD_CYC) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // Check every accepted result beat against the oldest expectation.
    always @(posedge i_clk) begin
        t_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_beats.size() == 0) begin
                $display("%0t: unexpected beat hit=%0b word=%h last=%0b",
                         $time, o_hit, o_word_out, o_last);
                n_errors++;
            end else begin
                want = pending_beats.pop_front();
                if (o_hit !== want.hit) begin
                    $display("%0t: hit expected %0b actual %0b", $time, want.hit, o_hit);
                    n_errors++;
                end
                if (o_word_out !== want.word) begin
                    $display("%0t: word expected %h actual %h", $time, want.word, o_word_out);
                    n_errors++;
                end
                if (o_last !== want.last) begin
                    $display("%0t: last expected %0b actual %0b", $time, want.last, o_last);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog
    int unsigned cyc_count = 0;
    always @(posedge i_clk) begin
        cyc_count <= cyc_count + 1;
        if (cyc_count >= CYC_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    t_stim_row        dir_tab[21];
    logic [KEY_W-1:0] key_pool[8];

    initial begin
        int               choice;
        int               n_sent;
        int               n_words;
        logic [KEY_W-1:0] k;
        n_errors        = 0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        start_hold      = 1'b0;
        ring_ptr        = 0;
        stage_pos       = 0;
        for (int i = 0; i < CAPACITY; i++) slot_vld[i] = 1'b0;
        for (int i = 0; i < ROW_WORDS; i++) stage_row[i] = '0;

        // Directed: misses after reset, a row with extreme words whose keys
        // differ (final key wins), and a lookup while a row is half staged.
        dir_tab = '{
            '{OP_LOOKUP, 64'h0,                 32'h0,        1'b1},
            '{OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1},
            '{OP_STORE,  64'h0,                 32'h0000_0000, 1'b0},
            '{OP_STORE,  64'h0,                 32'hFFFF_FFFF, 1'b0},
            '{OP_STORE,  64'h0,                 32'hAAAA_AAAA, 1'b0},
            '{OP_STORE,  64'h0,                 32'h5555_5555, 1'b0},
            '{OP_STORE,  64'h0,                 32'h8000_0000, 1'b0},
            '{OP_STORE,  64'h0,                 32'h0000_0001, 1'b0},
            '{OP_STORE,  64'h0,                 32'h7FFF_FFFF, 1'b0},
            '{OP_STORE,  64'h0,                 32'hFFFF_FFFE, 1'b0},
            '{OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'h1234_5678, 1'b1},
            '{OP_STORE,  64'h5555_5555_5555_5555, 32'h3F80_0000, 1'b0},
            '{OP_STORE,  64'hAAAA_AAAA_AAAA_AAAA, 32'hBF80_0000, 1'b0},
            '{OP_STORE,  64'h0,                 32'h0F0F_0F0F, 1'b0},
            '{OP_STORE,  64'h0,                 32'hF0F0_F0F0, 1'b0},
            '{OP_STORE,  64'h0,                 32'h00FF_00FF, 1'b0},
            '{OP_STORE,  64'h0,                 32'hFF00_FF00, 1'b0},
            '{OP_STORE,  64'h0,                 32'hDEAD_BEEF, 1'b0},
            '{OP_STORE,  64'hFFFF_FFFF_FFFF_FFFF, 32'hC0FF_EE00, 1'b0},
            '{OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0,        1'b0},
            '{OP_LOOKUP, 64'h0,                 32'h0,        1'b1}
        };

        key_pool[0] = 64'h0;
        key_pool[1] = 64'hFFFF_FFFF_FFFF_FFFF;
        for (int i = 2; i < 8; i++) key_pool[i] = {$urandom, $urandom};

        // Hold reset, then release it.
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i])
            offer_beat(dir_tab[i].op, dir_tab[i].key, dir_tab[i].word,
                       dir_tab[i].miss_known);

        // Random part: mostly whole rows on a small key pool (so keys get
        // stored again), lookups of pool and fresh keys, and stray stores.
        n_sent = 0;
        while (n_sent < N_RANDOM) begin
            case (n_sent * 4 / N_RANDOM)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin sender_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            // one long receiver hold-off while the sender keeps offering
            if (n_sent > 20 && !start_hold) start_hold = 1'b1;
            choice = $urandom_range(99);
            if (choice < 45) begin
                k = key_pool[$urandom_range(7)];
                for (int w = 0; w < ROW_WORDS; w++) begin
                    if (w == ROW_WORDS - 1 && $urandom_range(9) == 0) begin
                        k = {$urandom, $urandom};
                        key_pool[$urandom_range(7, 2)] = k;
                    end
                    offer_beat(OP_STORE, k, $urandom, 1'b0);
                end
                n_sent += ROW_WORDS;
            end else if (choice < 80) begin
                offer_beat(OP_LOOKUP, key_pool[$urandom_range(7)], $urandom, 1'b0);
                n_sent++;
            end else if (choice < 90) begin
                offer_beat(OP_LOOKUP, {$urandom, $urandom}, $urandom, 1'b0);
                n_sent++;
            end else begin
                // stray words: knock the row alignment off
                n_words = $urandom_range(5, 1);
                for (int w = 0; w < n_words; w++)
                    offer_beat(OP_STORE, {$urandom, $urandom}, $urandom, 1'b0);
                n_sent += n_words;
            end
        end
        // drop valid at the edge that took the final beat
        i_in_valid <= 1'b0;

        // Drain, then let the block settle.
        wait (pending_beats.size() == 0);
        repeat (CAPACITY + 40) @(posedge i_clk);
        if (n_errors == 0 && pending_beats.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/fkrc_pkg.sv
src/fkrc_cell.sv
src/fkrc_chain.sv
src/fkrc_row_mem.sv
src/fifo_keyed_row_cache.sv
test/fifo_keyed_row_cache_tb.sv
